// ===== hw/rtl/mfd_pkg.sv =====
// Shared types, constants and codes of the metaball field density core.
`timescale 1ns / 1ps

package mfd_pkg;

  // Field widths
  localparam int unsigned CW  = 24;  // coordinates, weight, thresholds, density
  localparam int unsigned RW  = 23;  // radius
  localparam int unsigned BIW = 4;   // ball_index field
  localparam int unsigned BCW = 5;   // ball_count register

  // APB port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_BALL_COUNT     = 2'd0;
  localparam logic [1:0] REG_THRESHOLD_LOW  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD_HIGH = 2'd2;
  localparam logic [1:0] REG_POSITIVE_ONLY  = 2'd3;

  // Register reset values
  localparam logic [BCW-1:0] BALL_COUNT_RST     = '0;
  localparam logic [CW-1:0]  THRESHOLD_LOW_RST  = 24'd0;
  localparam logic [CW-1:0]  THRESHOLD_HIGH_RST = 24'd4096;

  // Item kinds
  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Arithmetic constants
  localparam int unsigned NUM_LIM_EXP = 40;       // numerator saturates at +-2^40
  localparam int unsigned QW          = CW + 1;   // normalizing quotient bits
  localparam int unsigned TW          = CW + 18;  // magnitude of one ball term
  localparam logic [CW-1:0] OUT_MAX   = 24'h7FFFFF;
  localparam logic [CW-1:0] OUT_MIN   = 24'h800000;

  // Parameter defaults
  localparam int unsigned MAX_BALLS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 12;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_DIFF,
    S_SQ,
    S_SUM,
    S_INIT,
    S_DIV,
    S_N,
    S_M2,
    S_M3,
    S_TERM,
    S_ACC,
    S_NORM,
    S_QCHK,
    S_QDIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic diff;
    logic sq;
    logic sum;
    logic init;
    logic div_step;
    logic calc_n;
    logic m2;
    logic m3;
    logic term;
    logic acc;
    logic norm;
    logic qchk;
    logic qdiv_step;
    logic out_wr;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_ball;
    logic rad_zero;
    logic cap;
    logic skip;
    logic err;
    logic ovf;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mfd_ctrl.sv =====
// Sequencer of the metaball field density core: state machine and step counter.
`timescale 1ns / 1ps

module mfd_ctrl #(
  parameter int unsigned FRAC_BITS = mfd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  input  mfd_pkg::sts_t sts_i,
  output mfd_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  localparam int unsigned DIV_STEPS = FRAC_BITS + 6;
  localparam int unsigned MAX_STEPS =
    (DIV_STEPS > mfd_pkg::QW) ? DIV_STEPS : mfd_pkg::QW;
  localparam int unsigned SCW = $clog2(MAX_STEPS);

  mfd_pkg::state_e state_q, state_d;
  logic [SCW-1:0]  step_q, step_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mfd_pkg::S_IDLE: begin
        if (in_valid_i && (kind_i == mfd_pkg::KIND_EVAL)) begin
          state_d = sts_i.count_zero ? mfd_pkg::S_NORM : mfd_pkg::S_RD;
        end
      end
      mfd_pkg::S_RD:   state_d = mfd_pkg::S_DIFF;
      mfd_pkg::S_DIFF: state_d = mfd_pkg::S_SQ;
      mfd_pkg::S_SQ:   state_d = mfd_pkg::S_SUM;
      mfd_pkg::S_SUM:  state_d = mfd_pkg::S_INIT;
      mfd_pkg::S_INIT: begin
        if (sts_i.rad_zero) begin
          state_d = mfd_pkg::S_ACC;
        end else if (sts_i.cap) begin
          state_d = mfd_pkg::S_N;
        end else begin
          state_d = mfd_pkg::S_DIV;
        end
      end
      mfd_pkg::S_DIV: begin
        if (step_q == '0) state_d = mfd_pkg::S_N;
      end
      mfd_pkg::S_N:    state_d = sts_i.skip ? mfd_pkg::S_ACC : mfd_pkg::S_M2;
      mfd_pkg::S_M2:   state_d = mfd_pkg::S_M3;
      mfd_pkg::S_M3:   state_d = mfd_pkg::S_TERM;
      mfd_pkg::S_TERM: state_d = mfd_pkg::S_ACC;
      mfd_pkg::S_ACC:  state_d = sts_i.last_ball ? mfd_pkg::S_NORM : mfd_pkg::S_RD;
      mfd_pkg::S_NORM: state_d = mfd_pkg::S_QCHK;
      mfd_pkg::S_QCHK: begin
        state_d = (sts_i.err || sts_i.ovf) ? mfd_pkg::S_OUT : mfd_pkg::S_QDIV;
      end
      mfd_pkg::S_QDIV: begin
        if (step_q == '0) state_d = mfd_pkg::S_OUT;
      end
      mfd_pkg::S_OUT: begin
        if (sts_i.out_free) state_d = mfd_pkg::S_IDLE;
      end
      default: state_d = mfd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (state_q == mfd_pkg::S_INIT) begin
      step_d = SCW'(DIV_STEPS - 1);
    end else if (state_q == mfd_pkg::S_QCHK) begin
      step_d = SCW'(mfd_pkg::QW - 1);
    end else if ((state_q == mfd_pkg::S_DIV) || (state_q == mfd_pkg::S_QDIV)) begin
      step_d = step_q - SCW'(1);
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == mfd_pkg::S_IDLE) && in_valid_i &&
                      (kind_i == mfd_pkg::KIND_LOAD);
    cmd_o.start     = (state_q == mfd_pkg::S_IDLE) && in_valid_i &&
                      (kind_i == mfd_pkg::KIND_EVAL);
    cmd_o.rd        = (state_q == mfd_pkg::S_RD);
    cmd_o.diff      = (state_q == mfd_pkg::S_DIFF);
    cmd_o.sq        = (state_q == mfd_pkg::S_SQ);
    cmd_o.sum       = (state_q == mfd_pkg::S_SUM);
    cmd_o.init      = (state_q == mfd_pkg::S_INIT);
    cmd_o.div_step  = (state_q == mfd_pkg::S_DIV);
    cmd_o.calc_n    = (state_q == mfd_pkg::S_N);
    cmd_o.m2        = (state_q == mfd_pkg::S_M2);
    cmd_o.m3        = (state_q == mfd_pkg::S_M3);
    cmd_o.term      = (state_q == mfd_pkg::S_TERM);
    cmd_o.acc       = (state_q == mfd_pkg::S_ACC);
    cmd_o.norm      = (state_q == mfd_pkg::S_NORM);
    cmd_o.qchk      = (state_q == mfd_pkg::S_QCHK);
    cmd_o.qdiv_step = (state_q == mfd_pkg::S_QDIV);
    cmd_o.out_wr    = (state_q == mfd_pkg::S_OUT) && sts_i.out_free;
    in_stall_o      = (state_q != mfd_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfd_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== hw/rtl/mfd_datapath.sv =====
// Datapath of the metaball field density core: ball table, arithmetic, result register.
`timescale 1ns / 1ps

module mfd_datapath #(
  parameter int unsigned MAX_BALLS = mfd_pkg::MAX_BALLS_DEF,
  parameter int unsigned FRAC_BITS = mfd_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfd_pkg::cmd_t             cmd_i,
  output mfd_pkg::sts_t             sts_o,
  input  logic [mfd_pkg::BIW-1:0]   ball_index_i,
  input  logic [mfd_pkg::CW-1:0]    coord_x_i,
  input  logic [mfd_pkg::CW-1:0]    coord_y_i,
  input  logic [mfd_pkg::RW-1:0]    radius_i,
  input  logic [mfd_pkg::CW-1:0]    weight_i,
  input  logic [mfd_pkg::BCW-1:0]   ball_count_i,
  input  logic [mfd_pkg::CW-1:0]    threshold_low_i,
  input  logic [mfd_pkg::CW-1:0]    threshold_high_i,
  input  logic                      positive_only_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mfd_pkg::CW-1:0]    density_o,
  output logic                      error_flag_o
);

  localparam int unsigned CW    = mfd_pkg::CW;
  localparam int unsigned RW    = mfd_pkg::RW;
  localparam int unsigned QW    = mfd_pkg::QW;
  localparam int unsigned TW    = mfd_pkg::TW;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned AW    = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_BALLS + 1);
  localparam int unsigned IXW   = (AW > mfd_pkg::BIW) ? AW : mfd_pkg::BIW;
  localparam int unsigned KW    = (CNTW > mfd_pkg::BCW) ? CNTW : mfd_pkg::BCW;
  localparam int unsigned ENTW  = 3 * CW + RW;
  localparam int unsigned D2W   = 2 * CW + 1;
  localparam int unsigned R2W   = 2 * RW;
  localparam int unsigned REMW  = R2W + 6;
  localparam int unsigned RTW   = F + 7;
  localparam int unsigned NW    = F + 8;
  localparam int unsigned MW    = F + 6;
  localparam int unsigned M2W   = F + 12;
  localparam int unsigned M3W   = F + 18;
  localparam int unsigned SW    = TW + CNTW + 1;
  localparam int unsigned NFW   = SW + 1;
  localparam int unsigned NMW   = mfd_pkg::NUM_LIM_EXP + 1;
  localparam int unsigned NSW   = NMW + F;
  localparam int unsigned DMW   = CW + 1;
  localparam int unsigned QREMW = DMW + QW + 1;
  localparam int unsigned XW    = ((NSW > DMW + QW) ? NSW : DMW + QW) + 1;

  localparam logic [NW-1:0]  ONE_F   = NW'(1) << F;
  localparam logic [RTW-1:0] CAP_R   = RTW'(1) << (F + 6);
  localparam logic [NFW-1:0] NUM_LIM = NFW'(1) << mfd_pkg::NUM_LIM_EXP;
  localparam logic [QW-1:0]  POS_LIM = QW'(mfd_pkg::OUT_MAX);
  localparam logic [QW-1:0]  NEG_LIM = QW'(mfd_pkg::OUT_MAX) + QW'(1);

  // Ball table: {center x, center y, radius, weight}
  logic [ENTW-1:0] mem [MAX_BALLS];
  logic [ENTW-1:0] rd_q;

  logic [IXW-1:0]  wr_ext;
  logic            wr_ok;
  logic [CNTW-1:0] idx_q, count_q;
  logic [CW-1:0]   px_q, py_q;

  logic [CW-1:0]   cx, cy, wt;
  logic [RW-1:0]   rad;

  logic [CW-1:0]   ux_q, uy_q;
  logic [2*CW-1:0] ux2_q, uy2_q;
  logic [R2W-1:0]  r2_q;
  logic [D2W-1:0]  d2_q;
  logic [REMW-1:0] rem_q;
  logic [RTW-1:0]  quo_q;
  logic [MW-1:0]   m_q;
  logic            nneg_q;
  logic [M2W-1:0]  m2_q;
  logic [M3W-1:0]  m3_q;
  logic [TW-1:0]   t_q;
  logic            tneg_q;
  logic signed [SW-1:0] sum_q;
  logic            err_q;
  logic [NSW-1:0]  nsh_q;
  logic [DMW-1:0]  dmag_q;
  logic            qneg_q;
  logic            ovf_q;
  logic [QREMW-1:0] qrem_q;
  logic [QW-1:0]   qm_q;
  logic            out_valid_q;
  logic [CW-1:0]   density_q;
  logic            error_flag_q;

  // Combinational helpers
  logic signed [CW:0]  dx, dy;
  logic [REMW-1:0]     dvs, rem_sub;
  logic                rem_ge;
  logic signed [NW-1:0] n_val;
  logic [2*MW-1:0]     p_m2;
  logic [M2W+MW-1:0]   p_m3;
  logic [CW-1:0]       wmag;
  logic [CW+M3W-1:0]   p_t;
  logic [SW-1:0]       t_ext;
  logic signed [NFW-1:0] num_full;
  logic [NFW-1:0]      num_mag;
  logic [NMW-1:0]      nmag;
  logic signed [CW:0]  den;
  logic                ovf_c;
  logic [QREMW-1:0]    qdv, qrem_sub;
  logic                qrem_ge;
  logic [QW-1:0]       qm_neg;
  logic [CW-1:0]       res;

  assign wr_ext = IXW'(ball_index_i);
  assign wr_ok  = {1'b0, wr_ext} < (IXW + 1)'(MAX_BALLS);

  assign cx  = rd_q[ENTW-1 -: CW];
  assign cy  = rd_q[ENTW-CW-1 -: CW];
  assign rad = rd_q[CW+RW-1 -: RW];
  assign wt  = rd_q[CW-1:0];

  assign dx = $signed({px_q[CW-1], px_q}) - $signed({cx[CW-1], cx});
  assign dy = $signed({py_q[CW-1], py_q}) - $signed({cy[CW-1], cy});

  assign dvs     = REMW'({r2_q, 5'b0});
  assign rem_ge  = rem_q >= dvs;
  assign rem_sub = rem_ge ? (rem_q - dvs) : rem_q;

  assign n_val = $signed(ONE_F) - $signed({1'b0, quo_q});

  assign p_m2 = {{MW{1'b0}}, m_q} * {{MW{1'b0}}, m_q};
  assign p_m3 = {{MW{1'b0}}, m2_q} * {{M2W{1'b0}}, m_q};
  assign wmag = wt[CW-1] ? (~wt + CW'(1)) : wt;
  assign p_t  = {{M3W{1'b0}}, wmag} * {{CW{1'b0}}, m3_q};
  assign t_ext = SW'(t_q);

  assign num_full = NFW'(sum_q) - NFW'($signed(threshold_low_i));
  assign num_mag  = num_full[NFW-1] ? (~num_full + NFW'(1)) : num_full;
  assign nmag     = (num_mag > NUM_LIM) ? NMW'(NUM_LIM) : num_mag[NMW-1:0];
  assign den      = $signed({threshold_high_i[CW-1], threshold_high_i}) -
                    $signed({threshold_low_i[CW-1], threshold_low_i});

  assign ovf_c    = XW'(nsh_q) >= XW'({dmag_q, {QW{1'b0}}});
  assign qdv      = QREMW'({dmag_q, {(QW - 1){1'b0}}});
  assign qrem_ge  = qrem_q >= qdv;
  assign qrem_sub = qrem_ge ? (qrem_q - qdv) : qrem_q;
  assign qm_neg   = ~qm_q + QW'(1);

  // Saturate and sign the quotient; an error forces the positive limit
  always_comb begin
    if (err_q) begin
      res = mfd_pkg::OUT_MAX;
    end else if (qneg_q) begin
      res = (ovf_q || (qm_q > NEG_LIM)) ? mfd_pkg::OUT_MIN : qm_neg[CW-1:0];
    end else begin
      res = (ovf_q || (qm_q > POS_LIM)) ? mfd_pkg::OUT_MAX : qm_q[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem[wr_ext[AW-1:0]] <= {coord_x_i, coord_y_i, radius_i, weight_i};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q    <= coord_x_i;
      py_q    <= coord_y_i;
      sum_q   <= '0;
      err_q   <= 1'b0;
      idx_q   <= '0;
      count_q <= (KW'(ball_count_i) > KW'(MAX_BALLS)) ? CNTW'(MAX_BALLS)
                                                      : CNTW'(ball_count_i);
    end
    if (cmd_i.diff) begin
      ux_q <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      uy_q <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
    end
    if (cmd_i.sq) begin
      ux2_q <= {{CW{1'b0}}, ux_q} * {{CW{1'b0}}, ux_q};
      uy2_q <= {{CW{1'b0}}, uy_q} * {{CW{1'b0}}, uy_q};
      r2_q  <= {{RW{1'b0}}, rad} * {{RW{1'b0}}, rad};
    end
    if (cmd_i.sum) begin
      d2_q <= {1'b0, ux2_q} + {1'b0, uy2_q};
    end
    if (cmd_i.init) begin
      if (sts_o.rad_zero) begin
        err_q  <= 1'b1;
        t_q    <= '0;
        tneg_q <= 1'b0;
      end else if (sts_o.cap) begin
        quo_q <= CAP_R;
      end else begin
        rem_q <= REMW'(d2_q);
        quo_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= {rem_sub[REMW-2:0], 1'b0};
      quo_q <= {quo_q[RTW-2:0], rem_ge};
    end
    if (cmd_i.calc_n) begin
      if (sts_o.skip) begin
        t_q    <= '0;
        tneg_q <= 1'b0;
      end else begin
        m_q    <= n_val[NW-1] ? MW'(-n_val) : n_val[MW-1:0];
        nneg_q <= n_val[NW-1];
      end
    end
    if (cmd_i.m2) begin
      m2_q <= p_m2[2*MW-1:F];
    end
    if (cmd_i.m3) begin
      m3_q <= p_m3[M2W+MW-1:F];
    end
    if (cmd_i.term) begin
      t_q    <= p_t[CW+M3W-1:F];
      tneg_q <= nneg_q ^ wt[CW-1];
    end
    if (cmd_i.acc) begin
      sum_q <= tneg_q ? (sum_q - $signed(t_ext)) : (sum_q + $signed(t_ext));
      idx_q <= idx_q + CNTW'(1);
    end
    if (cmd_i.norm) begin
      nsh_q  <= {nmag, {F{1'b0}}};
      dmag_q <= den[CW] ? DMW'(-den) : DMW'(den);
      qneg_q <= num_full[NFW-1] ^ den[CW];
      if (den == '0) err_q <= 1'b1;
    end
    if (cmd_i.qchk) begin
      ovf_q  <= ovf_c;
      qrem_q <= QREMW'(nsh_q);
      qm_q   <= '0;
    end
    if (cmd_i.qdiv_step) begin
      qrem_q <= {qrem_sub[QREMW-2:0], 1'b0};
      qm_q   <= {qm_q[QW-2:0], qrem_ge};
    end
    if (cmd_i.out_wr) begin
      density_q    <= res;
      error_flag_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_wr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.count_zero = (ball_count_i == '0);
    sts_o.last_ball  = ((idx_q + CNTW'(1)) == count_q);
    sts_o.rad_zero   = (rad == '0);
    sts_o.cap        = {{(REMW - D2W){1'b0}}, d2_q} >= {r2_q, 6'b0};
    sts_o.skip       = positive_only_i && n_val[NW-1];
    sts_o.err        = err_q;
    sts_o.ovf        = ovf_c;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign density_o    = density_q;
  assign error_flag_o = error_flag_q;

endmodule

// ===== hw/rtl/metaball_field_density_core.sv =====
// Top level of the metaball field density core: APB registers, sequencer, datapath.
`timescale 1ns / 1ps

// Metaball field density core.
// Input channel (in_valid_i / in_stall_o): each item is either a load item
// (kind_i = 1) that writes one ball entry (center, radius, weight) at
// ball_index_i, or an evaluate item (kind_i = 0) that gives a sample point.
// Indexes at or above MAX_BALLS are dropped. Load items give no result.
// Output channel (out_valid_o / out_stall_i): one item per evaluate item,
// the normalized density (signed Q12.12, saturated) and an error flag that
// is set for a zero radius among the active balls or equal thresholds.
// Sequence: a load item is written while the block stays idle. An evaluate
// item runs the per-ball sequence through the table read port, the shared
// squaring/cube multipliers and a one-bit-per-cycle ratio divider, then a
// 25-step normalizing divider. A ball with zero radius or a clamped term
// finishes early. One item is worked on at a time.
// The result waits in an output register; a stalled receiver holds it, and
// the block accepts the next item meanwhile, holding a new result only
// until that register frees. Reset clears the control state and sets the
// registers to their reset values; the ball table is undefined until loaded.
// Program the APB registers only while the block is idle.
module metaball_field_density_core #(
  parameter int unsigned MAX_BALLS = mfd_pkg::MAX_BALLS_DEF,
  parameter int unsigned FRAC_BITS = mfd_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mfd_pkg::APB_AW-1:0]   paddr,
  input  logic [mfd_pkg::APB_DW-1:0]   pwdata,
  output logic [mfd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [mfd_pkg::BIW-1:0]      ball_index_i,
  input  logic [mfd_pkg::CW-1:0]       coord_x_i,
  input  logic [mfd_pkg::CW-1:0]       coord_y_i,
  input  logic [mfd_pkg::RW-1:0]       radius_i,
  input  logic [mfd_pkg::CW-1:0]       weight_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mfd_pkg::CW-1:0]       density_o,
  output logic                         error_flag_o
);

  logic [mfd_pkg::BCW-1:0] ball_count_q;
  logic [mfd_pkg::CW-1:0]  threshold_low_q;
  logic [mfd_pkg::CW-1:0]  threshold_high_q;
  logic                    positive_only_q;
  logic                    cfg_wr;
  logic [1:0]              cfg_idx;

  mfd_pkg::cmd_t cmd;
  mfd_pkg::sts_t sts;

  // APB: no wait states; write lands in the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_count_q     <= mfd_pkg::BALL_COUNT_RST;
      threshold_low_q  <= mfd_pkg::THRESHOLD_LOW_RST;
      threshold_high_q <= mfd_pkg::THRESHOLD_HIGH_RST;
      positive_only_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mfd_pkg::REG_BALL_COUNT:     ball_count_q     <= pwdata[mfd_pkg::BCW-1:0];
        mfd_pkg::REG_THRESHOLD_LOW:  threshold_low_q  <= pwdata[mfd_pkg::CW-1:0];
        mfd_pkg::REG_THRESHOLD_HIGH: threshold_high_q <= pwdata[mfd_pkg::CW-1:0];
        mfd_pkg::REG_POSITIVE_ONLY:  positive_only_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back: zero-extend each register
  always_comb begin
    case (cfg_idx)
      mfd_pkg::REG_BALL_COUNT:     prdata = mfd_pkg::APB_DW'(ball_count_q);
      mfd_pkg::REG_THRESHOLD_LOW:  prdata = mfd_pkg::APB_DW'(threshold_low_q);
      mfd_pkg::REG_THRESHOLD_HIGH: prdata = mfd_pkg::APB_DW'(threshold_high_q);
      mfd_pkg::REG_POSITIVE_ONLY:  prdata = mfd_pkg::APB_DW'(positive_only_q);
      default:                     prdata = '0;
    endcase
  end

  mfd_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .kind_i    (kind_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  mfd_datapath #(
    .MAX_BALLS(MAX_BALLS),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ball_index_i    (ball_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .radius_i        (radius_i),
    .weight_i        (weight_i),
    .ball_count_i    (ball_count_q),
    .threshold_low_i (threshold_low_q),
    .threshold_high_i(threshold_high_q),
    .positive_only_i (positive_only_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .density_o       (density_o),
    .error_flag_o    (error_flag_o)
  );

  // An error result always carries the positive saturated density
  a_err_density: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> density_o == mfd_pkg::OUT_MAX)
    else $error("error result without saturated density");

  // A new result is written only at the end of a busy evaluation
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an evaluation");

  // A load item leaves the block ready and never keeps it busy
  a_load_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == mfd_pkg::KIND_LOAD |=> !in_stall_o)
    else $error("load item kept the block busy");

endmodule

// ===== dv/metaball_field_density_core_tb.sv =====
// Self-checking testbench for the metaball field density core.
`timescale 1ns / 1ps

// Load ball entries and evaluate sample points through the valid/stall input
// channel, program the APB registers between phases, and check each density
// item against a cycle-free predictor of the cubic falloff sum and normalizing
// divide. Both channels idle at random; one phase runs with no idling at all.
module metaball_field_density_core_tb;

  localparam int unsigned TABLE_DEPTH = mfd_pkg::MAX_BALLS_DEF;
  localparam int unsigned FRAC = mfd_pkg::FRAC_BITS_DEF;
  // Long enough for the longest evaluate over a full table.
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [mfd_pkg::CW-1:0] density;
    logic                   error_flag;
  } density_item_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mfd_pkg::APB_AW-1:0]   paddr;
  logic [mfd_pkg::APB_DW-1:0]   pwdata;
  logic [mfd_pkg::APB_DW-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         kind_i;
  logic [mfd_pkg::BIW-1:0]      ball_index_i;
  logic [mfd_pkg::CW-1:0]       coord_x_i;
  logic [mfd_pkg::CW-1:0]       coord_y_i;
  logic [mfd_pkg::RW-1:0]       radius_i;
  logic [mfd_pkg::CW-1:0]       weight_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [mfd_pkg::CW-1:0]       density_o;
  logic                         error_flag_o;

  // Mirror of the ball table and the registers
  logic signed [mfd_pkg::CW-1:0] ball_cx [TABLE_DEPTH];
  logic signed [mfd_pkg::CW-1:0] ball_cy [TABLE_DEPTH];
  logic        [mfd_pkg::RW-1:0] ball_rad [TABLE_DEPTH];
  logic signed [mfd_pkg::CW-1:0] ball_wt [TABLE_DEPTH];
  logic [mfd_pkg::BCW-1:0]       cfg_count;
  logic signed [mfd_pkg::CW-1:0] cfg_low;
  logic signed [mfd_pkg::CW-1:0] cfg_high;
  logic                          cfg_pos_only;

  density_item_t density_expect_q[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  bit            idling_on = 1'b1;

  metaball_field_density_core i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .kind_i, .ball_index_i, .coord_x_i, .coord_y_i,
    .radius_i, .weight_i, .out_valid_o, .out_stall_i, .density_o, .error_flag_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Density predictor: cubic falloff per active ball, exact sum, then
  // saturated normalize against the thresholds.
  function automatic density_item_t predict_density(logic signed [mfd_pkg::CW-1:0] px,
                                                    logic signed [mfd_pkg::CW-1:0] py);
    density_item_t       item;
    longint              sum, num, den, res, n, dx, dy, w;
    longint unsigned     ux, uy, d2, r2, q, r, rem, m, m2, m3, t, qm, wm;
    int                  active;
    bit                  err;
    sum = 0;
    err = 1'b0;
    active = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
    for (int i = 0; i < active; i++) begin
      if (ball_rad[i] == '0) begin
        err = 1'b1;
        continue;
      end
      dx = longint'(px) - longint'(ball_cx[i]);
      dy = longint'(py) - longint'(ball_cy[i]);
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      d2 = ux * ux + uy * uy;
      r2 = longint'(ball_rad[i]) * longint'(ball_rad[i]);
      q = d2 / r2;
      if (q >= 64) begin
        r = 64 << FRAC;
      end else begin
        rem = d2 - q * r2;
        r = q;
        for (int k = 0; k < FRAC; k++) begin
          rem = rem << 1;
          r = r << 1;
          if (rem >= r2) begin
            rem = rem - r2;
            r = r | 1;
          end
        end
      end
      n = (longint'(1) << FRAC) - longint'(r);
      if (n < 0 && cfg_pos_only) continue;
      m = (n < 0) ? -n : n;
      m2 = (m * m) >> FRAC;
      m3 = (m2 * m) >> FRAC;
      w = longint'(ball_wt[i]);
      wm = (w < 0) ? -w : w;
      t = (wm * m3) >> FRAC;
      sum += ((n < 0) != (w < 0)) ? -longint'(t) : longint'(t);
    end
    den = longint'(cfg_high) - longint'(cfg_low);
    if (den == 0) err = 1'b1;
    if (err) begin
      res = 64'sd8388607;
    end else begin
      num = sum - longint'(cfg_low);
      if (num > (longint'(1) << 40)) num = longint'(1) << 40;
      if (num < -(longint'(1) << 40)) num = -(longint'(1) << 40);
      qm = (longint'((num < 0) ? -num : num) << FRAC) / longint'((den < 0) ? -den : den);
      if (qm > (longint'(1) << 40)) qm = longint'(1) << 40;
      res = ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
      if (res > 64'sd8388607) res = 64'sd8388607;
      if (res < -64'sd8388608) res = -64'sd8388608;
    end
    item.density = res[mfd_pkg::CW-1:0];
    item.error_flag = err;
    return item;
  endfunction

  // Send one item; hold it until accepted, then record what it does.
  task automatic send_item(logic kind, logic [mfd_pkg::BIW-1:0] idx,
                           logic [mfd_pkg::CW-1:0] x, logic [mfd_pkg::CW-1:0] y,
                           logic [mfd_pkg::RW-1:0] rad, logic [mfd_pkg::CW-1:0] wt);
    // Insert a random gap before the item, lowering valid first.
    if (idling_on && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    ball_index_i <= idx;
    coord_x_i    <= x;
    coord_y_i    <= y;
    radius_i     <= rad;
    weight_i     <= wt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == mfd_pkg::KIND_LOAD) begin
      ball_cx[idx]  = x;
      ball_cy[idx]  = y;
      ball_rad[idx] = rad;
      ball_wt[idx]  = wt;
    end else begin
      density_expect_q.insert(density_expect_q.size(), predict_density(x, y));
    end
  endtask

  task automatic load_ball(int idx, int x, int y, int rad, int wt);
    send_item(mfd_pkg::KIND_LOAD, idx[mfd_pkg::BIW-1:0], x[mfd_pkg::CW-1:0],
              y[mfd_pkg::CW-1:0], rad[mfd_pkg::RW-1:0], wt[mfd_pkg::CW-1:0]);
  endtask

  task automatic eval_point(int x, int y);
    send_item(mfd_pkg::KIND_EVAL, mfd_pkg::BIW'($urandom), x[mfd_pkg::CW-1:0],
              y[mfd_pkg::CW-1:0], mfd_pkg::RW'($urandom), mfd_pkg::CW'($urandom));
  endtask

  // Drop valid, wait for every expected item, then let a worst-case load
  // or evaluate finish before touching the registers.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (density_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] reg_idx, logic [mfd_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (reg_idx)
      mfd_pkg::REG_BALL_COUNT:     cfg_count    = value[mfd_pkg::BCW-1:0];
      mfd_pkg::REG_THRESHOLD_LOW:  cfg_low      = value[mfd_pkg::CW-1:0];
      mfd_pkg::REG_THRESHOLD_HIGH: cfg_high     = value[mfd_pkg::CW-1:0];
      mfd_pkg::REG_POSITIVE_ONLY:  cfg_pos_only = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(int count, int low, int high, bit pos_only);
    write_reg(mfd_pkg::REG_BALL_COUNT, mfd_pkg::APB_DW'(count));
    write_reg(mfd_pkg::REG_THRESHOLD_LOW, mfd_pkg::APB_DW'(low));
    write_reg(mfd_pkg::REG_THRESHOLD_HIGH, mfd_pkg::APB_DW'(high));
    write_reg(mfd_pkg::REG_POSITIVE_ONLY, mfd_pkg::APB_DW'(pos_only));
  endtask

  // Reset values: no active balls, so the sum is zero and maps to zero.
  task automatic test_reset_defaults();
    eval_point(0, 0);
    eval_point(-8388608, 8388607);
    drain_and_settle();
  endtask

  // Fill the whole table so any ball count reads loaded entries only.
  task automatic test_table_fill();
    load_ball(0, 0, 0, 4096, 4096);
    load_ball(1, 8388607, -8388608, 8388607, 8388607);
    load_ball(2, -8388608, 8388607, 1, -8388608);
    for (int i = 3; i < TABLE_DEPTH; i++)
      load_ball(i, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                $urandom_range(1, 40000), $urandom_range(0, 32767) - 16384);
  endtask

  // Falloff shape on one unit ball, extreme sample points, zero radius,
  // equal and reversed thresholds, positive-only clamp, oversize count.
  task automatic test_directed_cases();
    drain_and_settle();
    configure(1, 0, 4096, 1'b0);
    eval_point(0, 0);          // center: full weight
    eval_point(2048, 0);       // inside the ball
    eval_point(4096, 0);       // on the edge
    eval_point(8192, 4096);    // outside, negative base term
    eval_point(8388607, -8388608);
    drain_and_settle();
    configure(1, 0, 4096, 1'b1);
    eval_point(8192, 4096);    // clamped to zero
    eval_point(1000, -1000);
    drain_and_settle();
    configure(3, -8388608, 8388607, 1'b0);
    eval_point(-8388608, 8388607);
    eval_point(0, 0);
    drain_and_settle();
    configure(2, 100, 100, 1'b0);  // equal thresholds
    eval_point(0, 0);
    drain_and_settle();
    configure(31, 8388607, -8388608, 1'b0);  // count clamps to the table size
    eval_point(123, -456);
    drain_and_settle();
    load_ball(5, 0, 0, 0, 4096);   // zero radius among active balls
    drain_and_settle();
    configure(16, 0, 4096, 1'b0);
    eval_point(0, 0);
    load_ball(5, 4096, 4096, 8192, -4096);
    eval_point(4096, 4096);
    drain_and_settle();
  endtask

  function automatic int pick_coord();
    if ($urandom_range(99) < 75) return $urandom_range(0, 131071) - 65536;
    return int'(mfd_pkg::CW'($urandom));
  endfunction

  // Random load and evaluate items under one register setting.
  task automatic test_random_phase(int count, int low, int high, bit pos_only, int items,
                                   bit pause_once);
    int rad;
    configure(count, low, high, pos_only);
    for (int i = 0; i < items; i++) begin
      if (pause_once && i == items / 2) begin
        // Hold off the sender until every result has come back.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (density_expect_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(99) / 34)
          0: rad = 0;
          1: rad = int'(mfd_pkg::RW'($urandom));
          default: rad = $urandom_range(1, 40000);
        endcase
        if (rad == 0 && $urandom_range(99) > 10) rad = 4096;
        load_ball($urandom_range(TABLE_DEPTH - 1), pick_coord(), pick_coord(), rad,
                  ($urandom_range(99) < 70) ? $urandom_range(0, 32767) - 16384
                                            : int'(mfd_pkg::CW'($urandom)));
      end else begin
        eval_point(pick_coord(), pick_coord());
      end
    end
    drain_and_settle();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    kind_i       <= mfd_pkg::KIND_EVAL;
    ball_index_i <= '0;
    coord_x_i    <= '0;
    coord_y_i    <= '0;
    radius_i     <= '0;
    weight_i     <= '0;
    cfg_count    = mfd_pkg::BALL_COUNT_RST;
    cfg_low      = mfd_pkg::THRESHOLD_LOW_RST;
    cfg_high     = mfd_pkg::THRESHOLD_HIGH_RST;
    cfg_pos_only = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_table_fill();
    test_directed_cases();
    test_random_phase(4, 0, 4096, 1'b0, 110, 1'b1);
    idling_on = 1'b0;
    test_random_phase(1, -4096, 8192, 1'b1, 90, 1'b0);
    idling_on = 1'b1;
    test_random_phase(16, -8388608, 8388607, 1'b0, 90, 1'b0);
    test_random_phase(8, 2048, -2048, 1'b1, 90, 1'b0);
    test_random_phase(0, -300, 300, 1'b0, 40, 1'b0);
    test_random_phase($urandom_range(2, 20), $urandom_range(0, 8191) - 4096,
                      $urandom_range(4097, 40000), $urandom_range(1), 110, 1'b0);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver stall: random about 27 in 100, none during the quiet phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= idling_on && ($urandom_range(99) < 27);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    density_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (density_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item density=%h error_flag=%b", $time, density_o,
                 error_flag_o);
      end else begin
        want = density_expect_q.pop_front();
        if (density_o !== want.density) begin
          mismatch_count++;
          $display("%0t: density expected %h actual %h", $time, want.density, density_o);
        end
        if (error_flag_o !== want.error_flag) begin
          mismatch_count++;
          $display("%0t: error_flag expected %b actual %b", $time, want.error_flag,
                   error_flag_o);
        end
      end
    end
  end

  // Watchdog: end the run after too long with no handshake of any kind.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== metaball_field_density_core.f =====
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_ctrl.sv
hw/rtl/mfd_datapath.sv
hw/rtl/metaball_field_density_core.sv
dv/metaball_field_density_core_tb.sv
